/* hdl/closest_point_on_triangle_assert.svh */
// assertion macros for the closest point on triangle block
`ifndef CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`ifndef SYNTHESIS
`define CPT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("closest point assertion failed");
`define CPT_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("closest point reset assertion failed");
`else
`define CPT_ASSERT(name, prop)
`define CPT_ASSERT_RST(name, prop)
`endif
`endif

/* hdl/cpt_pkg.sv */
// shared widths, types and helpers for the closest point on triangle block
package cpt_pkg;

  localparam int CW     = 24;               // coordinate width
  localparam int DW     = CW + 1;           // coordinate difference
  localparam int PW     = 2 * DW;           // product of two differences
  localparam int DOTW   = PW + 2;           // dot product
  localparam int EW     = DOTW + 1;         // difference of dot products
  localparam int HW     = DOTW / 2;         // low half of a split dot product
  localparam int HIW    = DOTW - HW;        // high half
  localparam int PPW    = DOTW + 1;         // partial product of halves
  localparam int VPW    = 2 * DOTW;         // product of two dot products
  localparam int VW     = VPW + 1;          // barycentric determinant
  localparam int TW     = VW + 2;           // weight and denominator
  localparam int NCK    = 4;                // chunks of a weight
  localparam int CKW    = (TW + NCK - 1) / NCK;
  localparam int PCW    = DW + CKW + 1;     // direction times chunk
  localparam int TSW    = DW + TW;          // direction times weight
  localparam int NUMW   = TSW + 1;          // numerator
  localparam int QW     = CW + 2;           // quotient bits
  localparam int N2W    = NUMW + 1;         // rounding numerator
  localparam int D2W    = TW;               // rounding denominator
  localparam int RSW    = QW + 2;           // start plus offset
  localparam int RW     = 3;
  localparam int IN_DW  = ((12 * CW + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * CW + 7) / 8) * 8;
  localparam int USER_W = RW + 1;

  localparam logic [RW-1:0] REG_A   = 3'd0;
  localparam logic [RW-1:0] REG_B   = 3'd1;
  localparam logic [RW-1:0] REG_C   = 3'd2;
  localparam logic [RW-1:0] REG_AB  = 3'd3;
  localparam logic [RW-1:0] REG_AC  = 3'd4;
  localparam logic [RW-1:0] REG_BC  = 3'd5;
  localparam logic [RW-1:0] REG_INT = 3'd6;

  typedef logic signed [CW-1:0]   coord_t;
  typedef coord_t [2:0]           vec_t;
  typedef logic signed [DW-1:0]   diff_t;
  typedef diff_t [2:0]            dvec_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef dot_t [5:0]             dots_t;
  typedef logic signed [VW-1:0]   vval_t;
  typedef logic signed [TW-1:0]   wt_t;
  typedef logic signed [NUMW-1:0] num_t;
  typedef num_t [2:0]             numv_t;

  typedef struct packed {
    logic          valid;
    logic [RW-1:0] region;
    logic          degenerate;
  } ctl_t;

  typedef struct packed {
    vec_t  a;
    vec_t  b;
    vec_t  c;
    dvec_t ab;
    dvec_t ac;
    dvec_t bc;
  } geo_t;

  typedef struct packed {
    vval_t va;
    vval_t vb;
    vval_t vc;
  } bary_t;

  typedef struct packed {
    vec_t          near;
    logic [RW-1:0] region;
    logic          degenerate;
  } res_t;

  function automatic logic le0(input logic signed [TW-1:0] x);
    return x[TW-1] || (x == '0);
  endfunction

  function automatic logic ge0(input logic signed [TW-1:0] x);
    return !x[TW-1];
  endfunction

endpackage

/* hdl/closest_point_on_triangle.sv */
// top level of the closest point on triangle pipeline
//
// channel  dir  tdata                                      tuser
// in_      in   query xyz, vertex a xyz, b xyz, c xyz      -
// out_     out  nearest x, y, z                            region, degenerate
//
// one item per cycle sustained while the output buffer is not full;
// the restoring divider resolves one quotient bit per stage
// reset is synchronous and clears the valid bits and the output buffer only
// a two-entry output buffer takes results while out_tready is low; the whole
// pipeline freezes only once that buffer holds two results, so nothing is lost

`include "closest_point_on_triangle_assert.svh"

module closest_point_on_triangle
  import cpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // query_x, query_y, query_z, vertex_a_x .. _z, vertex_b_x .. _z, vertex_c_x .. _z
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // nearest_x, nearest_y, nearest_z
  output logic [OUT_DW-1:0] out_tdata,
  // region, degenerate
  output logic [USER_W-1:0] out_tuser
);

  // pipeline advances as one unit; held only when the output buffer is full
  logic  en;
  ctl_t  ctl_in;
  vec_t  p_v, a_v, b_v, c_v;

  ctl_t  dots_ctl, bary_ctl, sel_ctl, div_ctl;
  geo_t  dots_geo, bary_geo;
  dots_t dots_d, bary_d;
  bary_t bary_v;
  vec_t  sel_start, div_near;
  wt_t   sel_den;
  numv_t sel_num;

  // output buffer
  res_t       fifo_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign ctl_in    = '{valid: in_tvalid, region: REG_A, degenerate: 1'b0};

  // unpack the input transfer, first field lowest
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_v[i] = in_tdata[i*CW +: CW];
      a_v[i] = in_tdata[(3+i)*CW +: CW];
      b_v[i] = in_tdata[(6+i)*CW +: CW];
      c_v[i] = in_tdata[(9+i)*CW +: CW];
    end
  end

  // edge vectors and dot products d1..d6
  cpt_dots u_dots (
    .clk, .rst_n, .en,
    .ctl_i (ctl_in),
    .p_i   (p_v),
    .a_i   (a_v),
    .b_i   (b_v),
    .c_i   (c_v),
    .ctl_o (dots_ctl),
    .geo_o (dots_geo),
    .dots_o(dots_d)
  );

  // va, vb, vc from products of split 52-bit dot products
  cpt_bary u_bary (
    .clk, .rst_n, .en,
    .ctl_i (dots_ctl),
    .geo_i (dots_geo),
    .dots_i(dots_d),
    .ctl_o (bary_ctl),
    .geo_o (bary_geo),
    .dots_o(bary_d),
    .bary_o(bary_v)
  );

  // feature selection; every case becomes start + num / den
  cpt_select u_sel (
    .clk, .rst_n, .en,
    .ctl_i  (bary_ctl),
    .geo_i  (bary_geo),
    .dots_i (bary_d),
    .bary_i (bary_v),
    .ctl_o  (sel_ctl),
    .start_o(sel_start),
    .den_o  (sel_den),
    .num_o  (sel_num)
  );

  // rounded quotient, offset from the start vertex, clamp
  cpt_div u_div (
    .clk, .rst_n, .en,
    .ctl_i  (sel_ctl),
    .start_i(sel_start),
    .den_i  (sel_den),
    .num_i  (sel_num),
    .ctl_o  (div_ctl),
    .near_o (div_near)
  );

  assign push = en && div_ctl.valid;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push)
      fifo_r[wr_r] <= '{near: div_near, region: div_ctl.region,
                        degenerate: div_ctl.degenerate};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = OUT_DW'(fifo_r[rd_r].near);
  assign out_tuser  = {fifo_r[rd_r].degenerate, fifo_r[rd_r].region};

  // a degenerate result only comes from the interior branch
  `CPT_ASSERT(a_deg_interior, out_tvalid && out_tuser[RW] |-> out_tuser[RW-1:0] == REG_INT)
  // the buffer never holds more than two results
  `CPT_ASSERT(a_cnt_bound, cnt_r != 2'd3)
  // leaving reset the buffer is empty and input is taken
  `CPT_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid && in_tready)

endmodule

/* hdl/cpt_dots.sv */
// edge vectors and the six dot products, three stages
module cpt_dots
  import cpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_i,
  input  vec_t  p_i,
  input  vec_t  a_i,
  input  vec_t  b_i,
  input  vec_t  c_i,
  output ctl_t  ctl_o,
  output geo_t  geo_o,
  output dots_t dots_o
);

  ctl_t  ctl_r [3];
  geo_t  geo_r [3];
  dvec_t ap_r, bp_r, cp_r;
  logic signed [PW-1:0] prod_r [6][3];
  dots_t dots_r;
  dvec_t lhs [6];
  dvec_t rhs [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 3; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= '{valid: ctl_i.valid, region: REG_A, degenerate: 1'b0};
      ctl_r[1] <= ctl_r[0];
      ctl_r[2] <= ctl_r[1];
    end
  end

  always_comb begin
    lhs[0] = geo_r[0].ab; rhs[0] = ap_r;
    lhs[1] = geo_r[0].ac; rhs[1] = ap_r;
    lhs[2] = geo_r[0].ab; rhs[2] = bp_r;
    lhs[3] = geo_r[0].ac; rhs[3] = bp_r;
    lhs[4] = geo_r[0].ab; rhs[4] = cp_r;
    lhs[5] = geo_r[0].ac; rhs[5] = cp_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[0].a <= a_i;
      geo_r[0].b <= b_i;
      geo_r[0].c <= c_i;
      for (int i = 0; i < 3; i++) begin
        geo_r[0].ab[i] <= DW'(b_i[i]) - DW'(a_i[i]);
        geo_r[0].ac[i] <= DW'(c_i[i]) - DW'(a_i[i]);
        geo_r[0].bc[i] <= DW'(c_i[i]) - DW'(b_i[i]);
        ap_r[i]        <= DW'(p_i[i]) - DW'(a_i[i]);
        bp_r[i]        <= DW'(p_i[i]) - DW'(b_i[i]);
        cp_r[i]        <= DW'(p_i[i]) - DW'(c_i[i]);
      end
      geo_r[1] <= geo_r[0];
      for (int k = 0; k < 6; k++)
        for (int i = 0; i < 3; i++)
          prod_r[k][i] <= PW'(lhs[k][i]) * PW'(rhs[k][i]);
      geo_r[2] <= geo_r[1];
      for (int k = 0; k < 6; k++)
        dots_r[k] <= DOTW'(prod_r[k][0]) + DOTW'(prod_r[k][1]) + DOTW'(prod_r[k][2]);
    end
  end

  assign ctl_o  = ctl_r[2];
  assign geo_o  = geo_r[2];
  assign dots_o = dots_r;

endmodule

/* hdl/cpt_bary.sv */
// barycentric determinants va, vb, vc from split products, three stages
module cpt_bary
  import cpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_i,
  input  geo_t  geo_i,
  input  dots_t dots_i,
  output ctl_t  ctl_o,
  output geo_t  geo_o,
  output dots_t dots_o,
  output bary_t bary_o
);

  ctl_t  ctl_r  [3];
  geo_t  geo_r  [3];
  dots_t dots_r [3];
  logic signed [PPW-1:0] pp_r [6][4];
  logic signed [VPW-1:0] m_r  [6];
  bary_t bary_r;
  dot_t  opx [6];
  dot_t  opy [6];
  logic signed [HIW-1:0] xh [6];
  logic signed [HIW-1:0] yh [6];
  logic signed [HW:0]    xl [6];
  logic signed [HW:0]    yl [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 3; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      ctl_r[1] <= ctl_r[0];
      ctl_r[2] <= ctl_r[1];
    end
  end

  // vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
  always_comb begin
    opx[0] = dots_i[0]; opy[0] = dots_i[3];
    opx[1] = dots_i[2]; opy[1] = dots_i[1];
    opx[2] = dots_i[4]; opy[2] = dots_i[1];
    opx[3] = dots_i[0]; opy[3] = dots_i[5];
    opx[4] = dots_i[2]; opy[4] = dots_i[5];
    opx[5] = dots_i[4]; opy[5] = dots_i[3];
    for (int k = 0; k < 6; k++) begin
      xh[k] = opx[k][DOTW-1:HW];
      yh[k] = opy[k][DOTW-1:HW];
      xl[k] = {1'b0, opx[k][HW-1:0]};
      yl[k] = {1'b0, opy[k][HW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo_r[0]  <= geo_i;
      dots_r[0] <= dots_i;
      for (int k = 0; k < 6; k++) begin
        pp_r[k][0] <= PPW'(xh[k] * yh[k]);
        pp_r[k][1] <= PPW'(xh[k] * yl[k]);
        pp_r[k][2] <= PPW'(xl[k] * yh[k]);
        pp_r[k][3] <= PPW'(xl[k] * yl[k]);
      end
      geo_r[1]  <= geo_r[0];
      dots_r[1] <= dots_r[0];
      for (int k = 0; k < 6; k++)
        m_r[k] <= (VPW'(pp_r[k][0]) <<< (2 * HW))
                + ((VPW'(pp_r[k][1]) + VPW'(pp_r[k][2])) <<< HW)
                + VPW'(pp_r[k][3]);
      geo_r[2]  <= geo_r[1];
      dots_r[2] <= dots_r[1];
      bary_r.vc <= VW'(m_r[0]) - VW'(m_r[1]);
      bary_r.vb <= VW'(m_r[2]) - VW'(m_r[3]);
      bary_r.va <= VW'(m_r[4]) - VW'(m_r[5]);
    end
  end

  assign ctl_o  = ctl_r[2];
  assign geo_o  = geo_r[2];
  assign dots_o = dots_r[2];
  assign bary_o = bary_r;

endmodule

/* hdl/cpt_select.sv */
// region decision and numerator build, four stages
module cpt_select
  import cpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_i,
  input  geo_t  geo_i,
  input  dots_t dots_i,
  input  bary_t bary_i,
  output ctl_t  ctl_o,
  output vec_t  start_o,
  output wt_t   den_o,
  output numv_t num_o
);

  ctl_t  ctl_r   [4];
  vec_t  start_r [4];
  wt_t   den_r   [4];
  dvec_t dir_r   [2];
  wt_t   w_r     [2];
  logic signed [PCW-1:0] pc_r [3][2][NCK];
  logic signed [TSW-1:0] ts_r [3][2];
  numv_t num_r;

  dot_t d1, d2, d3, d4, d5, d6;
  logic signed [EW-1:0] e1, e2;
  wt_t   tot, den_nxt, w1_nxt, w2_nxt;
  vec_t  start_nxt;
  dvec_t dir1_nxt, dir2_nxt;
  logic [RW-1:0] reg_nxt;
  logic  deg_nxt;
  logic signed [NCK*CKW-1:0] wx [2];
  logic signed [CKW:0]       ck [2][NCK];
  logic signed [TSW-1:0]     acc [3][2];

  always_comb begin
    d1 = dots_i[0]; d2 = dots_i[1]; d3 = dots_i[2];
    d4 = dots_i[3]; d5 = dots_i[4]; d6 = dots_i[5];
    e1 = EW'(d4) - EW'(d3);
    e2 = EW'(d5) - EW'(d6);
    tot = TW'(bary_i.va) + TW'(bary_i.vb) + TW'(bary_i.vc);
    reg_nxt   = REG_INT;
    deg_nxt   = 1'b0;
    start_nxt = geo_i.a;
    dir1_nxt  = geo_i.ab;
    dir2_nxt  = geo_i.ac;
    w1_nxt    = '0;
    w2_nxt    = '0;
    den_nxt   = TW'(1);
    if (le0(TW'(d1)) && le0(TW'(d2))) begin
      reg_nxt = REG_A;
    end else if (ge0(TW'(d3)) && le0(TW'(e1))) begin
      reg_nxt   = REG_B;
      start_nxt = geo_i.b;
    end else if (le0(TW'(bary_i.vc)) && ge0(TW'(d1)) && le0(TW'(d3))) begin
      reg_nxt = REG_AB;
      w1_nxt  = TW'(d1);
      den_nxt = TW'(d1) - TW'(d3);
    end else if (ge0(TW'(d6)) && le0(TW'(e2))) begin
      reg_nxt   = REG_C;
      start_nxt = geo_i.c;
    end else if (le0(TW'(bary_i.vb)) && ge0(TW'(d2)) && le0(TW'(d6))) begin
      reg_nxt  = REG_AC;
      dir1_nxt = geo_i.ac;
      w1_nxt   = TW'(d2);
      den_nxt  = TW'(d2) - TW'(d6);
    end else if (le0(TW'(bary_i.va)) && ge0(TW'(e1)) && ge0(TW'(e2))) begin
      reg_nxt   = REG_BC;
      start_nxt = geo_i.b;
      dir1_nxt  = geo_i.bc;
      w1_nxt    = TW'(e1);
      den_nxt   = TW'(e1) + TW'(e2);
    end else if (le0(tot)) begin
      deg_nxt = 1'b1;
    end else begin
      w1_nxt  = TW'(bary_i.vb);
      w2_nxt  = TW'(bary_i.vc);
      den_nxt = tot;
    end
    // zero-length edge: numerator is zero too, so a unit denominator gives start
    if (den_nxt == '0) den_nxt = TW'(1);
  end

  // weights split into chunks, low chunks unsigned, top chunk signed
  always_comb begin
    for (int t = 0; t < 2; t++) begin
      wx[t] = (NCK * CKW)'(w_r[t]);
      for (int j = 0; j < NCK; j++) begin
        if (j == NCK - 1)
          ck[t][j] = $signed({wx[t][NCK*CKW-1], wx[t][NCK*CKW-1 -: CKW]});
        else
          ck[t][j] = $signed({1'b0, wx[t][j*CKW +: CKW]});
      end
    end
    for (int i = 0; i < 3; i++)
      for (int t = 0; t < 2; t++) begin
        acc[i][t] = '0;
        for (int j = 0; j < NCK; j++)
          acc[i][t] = acc[i][t] + (TSW'(pc_r[i][t][j]) <<< (j * CKW));
      end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 4; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= '{valid: ctl_i.valid, region: reg_nxt, degenerate: deg_nxt};
      for (int s = 1; s < 4; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start_r[0] <= start_nxt;
      den_r[0]   <= den_nxt;
      dir_r[0]   <= dir1_nxt;
      dir_r[1]   <= dir2_nxt;
      w_r[0]     <= w1_nxt;
      w_r[1]     <= w2_nxt;
      for (int s = 1; s < 4; s++) begin
        start_r[s] <= start_r[s-1];
        den_r[s]   <= den_r[s-1];
      end
      for (int i = 0; i < 3; i++)
        for (int t = 0; t < 2; t++)
          for (int j = 0; j < NCK; j++)
            pc_r[i][t][j] <= PCW'(dir_r[t][i] * ck[t][j]);
      for (int i = 0; i < 3; i++)
        for (int t = 0; t < 2; t++)
          ts_r[i][t] <= acc[i][t];
      for (int i = 0; i < 3; i++)
        num_r[i] <= NUMW'(ts_r[i][0]) + NUMW'(ts_r[i][1]);
    end
  end

  assign ctl_o   = ctl_r[3];
  assign start_o = start_r[3];
  assign den_o   = den_r[3];
  assign num_o   = num_r;

endmodule

/* hdl/cpt_div.sv */
// rounded division per coordinate, one quotient bit per stage, then offset and clamp
module cpt_div
  import cpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  ctl_t  ctl_i,
  input  vec_t  start_i,
  input  wt_t   den_i,
  input  numv_t num_i,
  output ctl_t  ctl_o,
  output vec_t  near_o
);

  typedef struct packed {
    logic [D2W-1:0] rem;
    logic [QW-1:0]  low;
    logic [QW-1:0]  q;
    logic           ovf;
    logic           neg;
    coord_t         start;
  } lane_t;

  ctl_t            ctl0_r;
  logic [N2W-1:0]  num2_r  [3];
  logic            neg0_r  [3];
  logic [D2W-1:0]  den20_r;
  vec_t            start0_r;
  lane_t           lane_r  [QW+1][3];
  ctl_t            ctl_q   [QW+1];
  logic [D2W-1:0]  den2_q  [QW];
  ctl_t            ctl_out_r;
  vec_t            near_r;

  logic [NUMW-1:0] mag     [3];
  logic [QW-1:0]   qf      [3];
  logic signed [RSW-1:0] qs [3];
  logic signed [RSW-1:0] rs [3];
  vec_t            near_nxt;

  function automatic lane_t div_step(input lane_t l, input logic [D2W-1:0] dd);
    logic [D2W:0] tr;
    lane_t r;
    r   = l;
    tr  = {l.rem, l.low[QW-1]} - {1'b0, dd};
    r.low = {l.low[QW-2:0], 1'b0};
    if (!tr[D2W]) begin
      r.rem = tr[D2W-1:0];
      r.q   = {l.q[QW-2:0], 1'b1};
    end else begin
      r.rem = {l.rem[D2W-2:0], l.low[QW-1]};
      r.q   = {l.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++)
      mag[i] = num_i[i][NUMW-1] ? NUMW'(-num_i[i]) : NUMW'(num_i[i]);
    for (int i = 0; i < 3; i++) begin
      qf[i] = lane_r[QW][i].ovf ? '1 : lane_r[QW][i].q;
      qs[i] = $signed(RSW'(qf[i]));
      rs[i] = RSW'(lane_r[QW][i].start) + (lane_r[QW][i].neg ? -qs[i] : qs[i]);
      if (rs[i][RSW-1:CW-1] != '0 && rs[i][RSW-1:CW-1] != '1)
        near_nxt[i] = rs[i][RSW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      else
        near_nxt[i] = rs[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r    <= '0;
      ctl_out_r <= '0;
      for (int s = 0; s <= QW; s++) ctl_q[s] <= '0;
    end else if (en) begin
      ctl0_r   <= ctl_i;
      ctl_q[0] <= ctl0_r;
      for (int s = 1; s <= QW; s++) ctl_q[s] <= ctl_q[s-1];
      ctl_out_r <= ctl_q[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // round to nearest: (2|n| + d) / 2d, sign applied afterwards
      for (int i = 0; i < 3; i++) begin
        num2_r[i] <= (N2W'(mag[i]) << 1) + N2W'($unsigned(den_i));
        neg0_r[i] <= num_i[i][NUMW-1];
      end
      den20_r  <= D2W'($unsigned(den_i)) << 1;
      start0_r <= start_i;
      for (int i = 0; i < 3; i++) begin
        lane_r[0][i].ovf   <= num2_r[i][N2W-1:QW] >= (N2W-QW)'(den20_r);
        lane_r[0][i].rem   <= num2_r[i][D2W+QW-1:QW];
        lane_r[0][i].low   <= num2_r[i][QW-1:0];
        lane_r[0][i].q     <= '0;
        lane_r[0][i].neg   <= neg0_r[i];
        lane_r[0][i].start <= start0_r[i];
      end
      den2_q[0] <= den20_r;
      for (int s = 1; s < QW; s++) den2_q[s] <= den2_q[s-1];
      for (int s = 0; s < QW; s++)
        for (int i = 0; i < 3; i++)
          lane_r[s+1][i] <= div_step(lane_r[s][i], den2_q[s]);
      near_r <= near_nxt;
    end
  end

  assign ctl_o  = ctl_out_r;
  assign near_o = near_r;

endmodule
